@@ sv/imutcf_pkg.sv @@
package imutcf_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 32;
  localparam int PRE_LAST     = 8;
  localparam int POST_LAST    = 10;
  localparam int STEP_Q24     = 335544;
  localparam int LPF_OLD      = 29491;
  localparam int LPF_NEW      = 3277;
  localparam int ONE_Q15      = 32768;

  typedef struct packed {
    logic               sample_valid;
    logic signed [15:0] raw_accel_x;
    logic signed [15:0] raw_accel_y;
    logic signed [15:0] raw_accel_z;
    logic signed [15:0] raw_gyro_x;
    logic signed [15:0] raw_gyro_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] roll_deg;
    logic signed [31:0] pitch_deg;
    logic signed [31:0] angle_x_deg;
    logic signed [31:0] angle_y_deg;
    logic signed [31:0] smooth_accel_x;
    logic signed [31:0] smooth_accel_y;
  } out_item_t;

  localparam logic [2:0] REG_ACCEL_SCALE  = 3'd0;
  localparam logic [2:0] REG_GYRO_SCALE   = 3'd1;
  localparam logic [2:0] REG_ACCEL_BIAS_X = 3'd2;
  localparam logic [2:0] REG_ACCEL_BIAS_Y = 3'd3;
  localparam logic [2:0] REG_ACCEL_BIAS_Z = 3'd4;
  localparam logic [2:0] REG_GYRO_BIAS_X  = 3'd5;
  localparam logic [2:0] REG_GYRO_BIAS_Y  = 3'd6;
  localparam logic [2:0] REG_BLEND_WEIGHT = 3'd7;

  localparam logic [4:0] MUL_NONE = 5'd0;
  localparam logic [4:0] MUL_SAX  = 5'd1;
  localparam logic [4:0] MUL_SAY  = 5'd2;
  localparam logic [4:0] MUL_SAZ  = 5'd3;
  localparam logic [4:0] MUL_SGX  = 5'd4;
  localparam logic [4:0] MUL_SGY  = 5'd5;
  localparam logic [4:0] MUL_QAX  = 5'd6;
  localparam logic [4:0] MUL_QAZ  = 5'd7;
  localparam logic [4:0] MUL_QAY  = 5'd8;
  localparam logic [4:0] MUL_RGX  = 5'd9;
  localparam logic [4:0] MUL_RGY  = 5'd10;
  localparam logic [4:0] MUL_BG0  = 5'd11;
  localparam logic [4:0] MUL_BA0  = 5'd12;
  localparam logic [4:0] MUL_BG1  = 5'd13;
  localparam logic [4:0] MUL_BA1  = 5'd14;
  localparam logic [4:0] MUL_LO0  = 5'd15;
  localparam logic [4:0] MUL_LN0  = 5'd16;
  localparam logic [4:0] MUL_LO1  = 5'd17;
  localparam logic [4:0] MUL_LN1  = 5'd18;

  localparam logic [3:0] WB_NONE   = 4'd0;
  localparam logic [3:0] WB_HAX    = 4'd1;
  localparam logic [3:0] WB_HAY    = 4'd2;
  localparam logic [3:0] WB_HAZ    = 4'd3;
  localparam logic [3:0] WB_HGX    = 4'd4;
  localparam logic [3:0] WB_HGY    = 4'd5;
  localparam logic [3:0] WB_N0SET  = 4'd6;
  localparam logic [3:0] WB_N0N1   = 4'd7;
  localparam logic [3:0] WB_N1ADD  = 4'd8;
  localparam logic [3:0] WB_GA0    = 4'd9;
  localparam logic [3:0] WB_GA1    = 4'd10;
  localparam logic [3:0] WB_ACC    = 4'd11;
  localparam logic [3:0] WB_T0     = 4'd12;
  localparam logic [3:0] WB_T1     = 4'd13;
  localparam logic [3:0] WB_S0     = 4'd14;
  localparam logic [3:0] WB_S1     = 4'd15;

  typedef struct packed {
    logic       in_load;
    logic [4:0] mul_sel;
    logic [3:0] wb_sel;
    logic       sqrt_step;
    logic       cordic_init;
    logic       cordic_step;
    logic [4:0] cordic_idx;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0:    r = 32'sd2949120;
      5'd1:    r = 32'sd1740967;
      5'd2:    r = 32'sd919879;
      5'd3:    r = 32'sd466945;
      5'd4:    r = 32'sd234379;
      5'd5:    r = 32'sd117304;
      5'd6:    r = 32'sd58666;
      5'd7:    r = 32'sd29335;
      5'd8:    r = 32'sd14668;
      5'd9:    r = 32'sd7334;
      5'd10:   r = 32'sd3667;
      5'd11:   r = 32'sd1833;
      5'd12:   r = 32'sd917;
      5'd13:   r = 32'sd458;
      5'd14:   r = 32'sd229;
      5'd15:   r = 32'sd115;
      5'd16:   r = 32'sd57;
      5'd17:   r = 32'sd29;
      5'd18:   r = 32'sd14;
      5'd19:   r = 32'sd7;
      5'd20:   r = 32'sd4;
      5'd21:   r = 32'sd2;
      5'd22:   r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ sv/imutcf_if.sv @@
interface imutcf_in_if
  import imutcf_pkg::*;
  ;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface imutcf_out_if
  import imutcf_pkg::*;
  ;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ sv/imutcf_ctrl.sv @@
module imutcf_ctrl
  import imutcf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRE   = 3'd1;
  localparam logic [2:0] S_SQRT  = 3'd2;
  localparam logic [2:0] S_CINIT = 3'd3;
  localparam logic [2:0] S_CORD  = 3'd4;
  localparam logic [2:0] S_POST  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state, state_next;
  logic [4:0] cnt, cnt_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cnt_next   = cnt;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.in_load = in_valid;
        if (in_valid) begin
          state_next = S_PRE;
          cnt_next   = '0;
        end
      end
      S_PRE: begin
        unique case (cnt)
          5'd0:    cmd.mul_sel = MUL_SAX;
          5'd1:    begin cmd.mul_sel = MUL_SAY; cmd.wb_sel = WB_HAX; end
          5'd2:    begin cmd.mul_sel = MUL_SAZ; cmd.wb_sel = WB_HAY; end
          5'd3:    begin cmd.mul_sel = MUL_SGX; cmd.wb_sel = WB_HAZ; end
          5'd4:    begin cmd.mul_sel = MUL_SGY; cmd.wb_sel = WB_HGX; end
          5'd5:    begin cmd.mul_sel = MUL_QAX; cmd.wb_sel = WB_HGY; end
          5'd6:    begin cmd.mul_sel = MUL_QAZ; cmd.wb_sel = WB_N0SET; end
          5'd7:    begin cmd.mul_sel = MUL_QAY; cmd.wb_sel = WB_N0N1; end
          default: cmd.wb_sel = WB_N1ADD;
        endcase
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(PRE_LAST)) begin
          state_next = S_SQRT;
          cnt_next   = '0;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 5'd1;
        if (cnt == 5'(SQRT_STEPS - 1)) begin
          state_next = S_CINIT;
          cnt_next   = '0;
        end
      end
      S_CINIT: begin
        cmd.cordic_init = 1'b1;
        state_next      = S_CORD;
        cnt_next        = '0;
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        cmd.cordic_idx  = cnt;
        cnt_next        = cnt + 5'd1;
        if (cnt == 5'(CORDIC_STEPS - 1)) begin
          state_next = S_POST;
          cnt_next   = '0;
        end
      end
      S_POST: begin
        unique case (cnt)
          5'd0:    cmd.mul_sel = MUL_RGX;
          5'd1:    begin cmd.mul_sel = MUL_RGY; cmd.wb_sel = WB_GA0; end
          5'd2:    begin cmd.mul_sel = MUL_BG0; cmd.wb_sel = WB_GA1; end
          5'd3:    begin cmd.mul_sel = MUL_BA0; cmd.wb_sel = WB_ACC; end
          5'd4:    begin cmd.mul_sel = MUL_BG1; cmd.wb_sel = WB_T0; end
          5'd5:    begin cmd.mul_sel = MUL_BA1; cmd.wb_sel = WB_ACC; end
          5'd6:    begin cmd.mul_sel = MUL_LO0; cmd.wb_sel = WB_T1; end
          5'd7:    begin cmd.mul_sel = MUL_LN0; cmd.wb_sel = WB_ACC; end
          5'd8:    begin cmd.mul_sel = MUL_LO1; cmd.wb_sel = WB_S0; end
          5'd9:    begin cmd.mul_sel = MUL_LN1; cmd.wb_sel = WB_ACC; end
          default: cmd.wb_sel = WB_S1;
        endcase
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(POST_LAST)) begin
          state_next = S_OUT;
          cnt_next   = '0;
        end
      end
      S_OUT: begin
        cmd.out_load = st.out_free;
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

`ifndef ASSERT_OFF
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result loaded while the output register is occupied");
  a_sqrt_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT && cnt == 5'(SQRT_STEPS - 1)) |=> cmd.cordic_init)
    else $error("square root did not hand over to the CORDIC");
  a_cord_first: assert property (@(posedge clk) disable iff (rst)
    cmd.cordic_init |=> (cmd.cordic_step && cmd.cordic_idx == 5'd0))
    else $error("CORDIC did not start at the first angle");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!cmd.sqrt_step && !cmd.cordic_step && cmd.wb_sel == WB_NONE))
    else $error("input offered while the datapath is busy");
`endif

endmodule

@@ sv/imutcf_dp.sv @@
module imutcf_dp
  import imutcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       st,
  input  in_item_t    in_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  logic [23:0]        accel_scale, gyro_scale;
  logic signed [31:0] accel_bias_x, accel_bias_y, accel_bias_z;
  logic signed [31:0] gyro_bias_x, gyro_bias_y;
  logic [15:0]        blend_weight;

  in_item_t           raw;
  logic signed [31:0] held_ax, held_ay, held_az, held_gx, held_gy;
  logic signed [31:0] tilt0, tilt1, smooth0, smooth1;
  logic signed [33:0] ga0, ga1;
  logic signed [71:0] acc;

  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [71:0] p72;
  logic [16:0]        w_eff, w_inv;

  logic [63:0]        rad [2];
  logic [34:0]        rem [2];
  logic [31:0]        root [2];
  logic signed [51:0] cx [2];
  logic signed [51:0] cy [2];
  logic signed [31:0] z [2];
  logic               zf [2];

  logic signed [31:0] bias_sel, scaled, ga_add;
  logic signed [31:0] mixed;
  logic signed [32:0] neg_ax;
  logic signed [31:0] roll, pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_scale  <= 24'd1024;
      gyro_scale   <= 24'd512000;
      accel_bias_x <= '0;
      accel_bias_y <= '0;
      accel_bias_z <= '0;
      gyro_bias_x  <= '0;
      gyro_bias_y  <= '0;
      blend_weight <= 16'd29491;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACCEL_SCALE:  accel_scale  <= cfg_data[23:0];
        REG_GYRO_SCALE:   gyro_scale   <= cfg_data[23:0];
        REG_ACCEL_BIAS_X: accel_bias_x <= cfg_data;
        REG_ACCEL_BIAS_Y: accel_bias_y <= cfg_data;
        REG_ACCEL_BIAS_Z: accel_bias_z <= cfg_data;
        REG_GYRO_BIAS_X:  gyro_bias_x  <= cfg_data;
        REG_GYRO_BIAS_Y:  gyro_bias_y  <= cfg_data;
        default:          blend_weight <= cfg_data[15:0];
      endcase
    end
  end

  assign w_eff = (blend_weight > 16'(ONE_Q15)) ? 17'(ONE_Q15) : {1'b0, blend_weight};
  assign w_inv = 17'(ONE_Q15) - w_eff;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_sel)
      MUL_SAX: begin ma = 34'(raw.raw_accel_x); mb = {10'b0, accel_scale}; end
      MUL_SAY: begin ma = 34'(raw.raw_accel_y); mb = {10'b0, accel_scale}; end
      MUL_SAZ: begin ma = 34'(raw.raw_accel_z); mb = {10'b0, accel_scale}; end
      MUL_SGX: begin ma = 34'(raw.raw_gyro_x);  mb = {10'b0, gyro_scale}; end
      MUL_SGY: begin ma = 34'(raw.raw_gyro_y);  mb = {10'b0, gyro_scale}; end
      MUL_QAX: begin ma = 34'(held_ax); mb = 34'(held_ax); end
      MUL_QAZ: begin ma = 34'(held_az); mb = 34'(held_az); end
      MUL_QAY: begin ma = 34'(held_ay); mb = 34'(held_ay); end
      MUL_RGX: begin ma = 34'(held_gx); mb = 34'(STEP_Q24); end
      MUL_RGY: begin ma = 34'(held_gy); mb = 34'(STEP_Q24); end
      MUL_BG0: begin ma = {17'b0, w_eff}; mb = ga0; end
      MUL_BA0: begin ma = {17'b0, w_inv}; mb = 34'(roll); end
      MUL_BG1: begin ma = {17'b0, w_eff}; mb = ga1; end
      MUL_BA1: begin ma = {17'b0, w_inv}; mb = 34'(pitch); end
      MUL_LO0: begin ma = 34'(LPF_OLD); mb = 34'(smooth0); end
      MUL_LN0: begin ma = 34'(LPF_NEW); mb = 34'(held_ax); end
      MUL_LO1: begin ma = 34'(LPF_OLD); mb = 34'(smooth1); end
      MUL_LN1: begin ma = 34'(LPF_NEW); mb = 34'(held_ay); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  assign p72 = 72'(prod);

  always_comb begin
    case (cmd.wb_sel)
      WB_HAX:  bias_sel = accel_bias_x;
      WB_HAY:  bias_sel = accel_bias_y;
      WB_HAZ:  bias_sel = accel_bias_z;
      WB_HGX:  bias_sel = gyro_bias_x;
      default: bias_sel = gyro_bias_y;
    endcase
  end

  assign scaled = sat32(((p72 + 72'sd128) >>> 8) - 72'(bias_sel));
  assign ga_add = 32'((p72 + 72'sd8388608) >>> 24);
  assign mixed  = sat32((acc + p72 + 72'sd16384) >>> 15);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_ax <= '0;
      held_ay <= '0;
      held_az <= '0;
      held_gx <= '0;
      held_gy <= '0;
      tilt0   <= '0;
      tilt1   <= '0;
      smooth0 <= '0;
      smooth1 <= '0;
    end else begin
      case (cmd.wb_sel)
        WB_HAX: if (raw.sample_valid) held_ax <= scaled;
        WB_HAY: if (raw.sample_valid) held_ay <= scaled;
        WB_HAZ: if (raw.sample_valid) held_az <= scaled;
        WB_HGX: if (raw.sample_valid) held_gx <= scaled;
        WB_HGY: if (raw.sample_valid) held_gy <= scaled;
        WB_T0:  tilt0   <= mixed;
        WB_T1:  tilt1   <= mixed;
        WB_S0:  smooth0 <= mixed;
        WB_S1:  smooth1 <= mixed;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      raw <= in_data;
    end
    case (cmd.wb_sel)
      WB_GA0: ga0 <= 34'(tilt0) + 34'(ga_add);
      WB_GA1: ga1 <= 34'(tilt1) + 34'(ga_add);
      WB_ACC: acc <= p72;
      default: begin
      end
    endcase
  end

  // Restoring square root, run on both lanes side by side.
  always_ff @(posedge clk) begin
    logic [34:0] rs;
    logic [34:0] tr;
    if (cmd.wb_sel == WB_N0SET) begin
      rad[0]  <= prod[63:0];
      rem[0]  <= '0;
      root[0] <= '0;
    end else if (cmd.wb_sel == WB_N0N1) begin
      rad[0]  <= rad[0] + prod[63:0];
      rad[1]  <= prod[63:0];
      rem[1]  <= '0;
      root[1] <= '0;
    end else if (cmd.wb_sel == WB_N1ADD) begin
      rad[1]  <= rad[1] + prod[63:0];
    end else if (cmd.sqrt_step) begin
      for (int k = 0; k < 2; k++) begin
        rs = {rem[k][32:0], rad[k][63:62]};
        tr = {1'b0, root[k], 2'b01};
        rad[k] <= {rad[k][61:0], 2'b00};
        if (rs >= tr) begin
          rem[k]  <= rs - tr;
          root[k] <= {root[k][30:0], 1'b1};
        end else begin
          rem[k]  <= rs;
          root[k] <= {root[k][30:0], 1'b0};
        end
      end
    end
  end

  assign neg_ax = -33'(held_ax);

  always_ff @(posedge clk) begin
    logic signed [51:0] dx;
    logic signed [51:0] dy;
    if (cmd.cordic_init) begin
      cx[0] <= {4'b0, root[0], 16'b0};
      cx[1] <= {4'b0, root[1], 16'b0};
      cy[0] <= {{4{held_ay[31]}}, held_ay, 16'b0};
      cy[1] <= {{3{neg_ax[32]}}, neg_ax, 16'b0};
      z[0]  <= '0;
      z[1]  <= '0;
      zf[0] <= (root[0] == '0) && (held_ay == '0);
      zf[1] <= (root[1] == '0) && (held_ax == '0);
    end else if (cmd.cordic_step) begin
      for (int k = 0; k < 2; k++) begin
        dx = cy[k] >>> cmd.cordic_idx;
        dy = cx[k] >>> cmd.cordic_idx;
        if (cy[k] < 0) begin
          cx[k] <= cx[k] - dx;
          cy[k] <= cy[k] + dy;
          z[k]  <= z[k] - atan_deg(cmd.cordic_idx);
        end else begin
          cx[k] <= cx[k] + dx;
          cy[k] <= cy[k] - dy;
          z[k]  <= z[k] + atan_deg(cmd.cordic_idx);
        end
      end
    end
  end

  assign roll  = zf[0] ? 32'sd0 : z[0];
  assign pitch = zf[1] ? 32'sd0 : z[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.roll_deg       <= roll;
      out_data.pitch_deg      <= pitch;
      out_data.angle_x_deg    <= tilt0;
      out_data.angle_y_deg    <= tilt1;
      out_data.smooth_accel_x <= smooth0;
      out_data.smooth_accel_y <= smooth1;
    end
  end

  assign st.out_free = !out_valid || out_ready;

endmodule

@@ sv/imu_tilt_complementary_filter.sv @@
// A new sample is taken only after the previous result is loaded into the output register.
// The pace is set by the 32-step square root and the 24-step CORDIC, both run for roll and
// pitch side by side, and by one shared multiplier.
// A finished result waits in the output register while the next sample is taken.
// Synchronous active-high reset restores the register defaults and clears the held, tilt and smoothing state.
module imu_tilt_complementary_filter
  import imutcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  imutcf_in_if.sink   sample_in,
  imutcf_out_if.source result_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;

  imutcf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in.valid),
    .in_ready (sample_in.ready),
    .st       (st),
    .cmd      (cmd)
  );

  imutcf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_data   (sample_in.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_data  (result_out.data)
  );

endmodule
